// ===== hdl/sha256_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants of the SHA-256 byte stream hasher: round
// constants, initial hash values and the controller/datapath command bus.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD80,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic      shift_en;
    byte_src_t byte_src;
    logic      count_inc;
    logic      load_vars;
    logic      round_en;
    logic [5:0] round_idx;
    logic      hash_add;
    logic      hash_init;
    logic [2:0] word_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/sha256_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_if
// Valid/ready channels of the hasher: byte input and digest word output.
// ----------------------------------------------------------------------------
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/sha256_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: byte absorb, finish padding, 64 compression rounds, hash update
// and digest word emission.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output sha256_pkg::dp_cmd_t cmd,
  input  sha256_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] round_r, round_nxt;
  logic [2:0] word_r, word_nxt;
  logic       fin_r, fin_nxt;
  logic       lastblk_r, lastblk_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    word_nxt      = word_r;
    fin_nxt       = fin_r;
    lastblk_nxt   = lastblk_r;
    cmd           = '0;
    cmd.byte_src  = sha256_pkg::SRC_ZERO;
    cmd.round_idx = round_r;
    cmd.word_idx  = word_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.shift_en = 1'b1;
          if (!in_op) begin
            cmd.byte_src  = sha256_pkg::SRC_DATA;
            cmd.count_inc = 1'b1;
          end else begin
            cmd.byte_src = sha256_pkg::SRC_PAD80;
            fin_nxt      = 1'b1;
            lastblk_nxt  = (sts.fill < sha256_pkg::LEN_POS);
            state_nxt    = ST_PAD;
          end
          if (sts.fill == sha256_pkg::BLOCK_LAST) begin
            cmd.load_vars = 1'b1;
            round_nxt     = '0;
            state_nxt     = ST_COMP;
          end
        end
      end
      ST_PAD: begin
        cmd.shift_en = 1'b1;
        if (lastblk_r && (sts.fill >= sha256_pkg::LEN_POS)) begin
          cmd.byte_src = sha256_pkg::SRC_LEN;
        end
        if (sts.fill == sha256_pkg::BLOCK_LAST) begin
          cmd.load_vars = 1'b1;
          round_nxt     = '0;
          state_nxt     = ST_COMP;
        end
      end
      ST_COMP: begin
        cmd.round_en = 1'b1;
        round_nxt    = round_r + 6'd1;
        if (round_r == sha256_pkg::ROUND_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.hash_add = 1'b1;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (lastblk_r) begin
          word_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          lastblk_nxt = 1'b1;
          state_nxt   = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (word_r == sha256_pkg::WORD_LAST) begin
            cmd.hash_init = 1'b1;
            fin_nxt       = 1'b0;
            lastblk_nxt   = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            word_nxt = word_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      round_r   <= '0;
      word_r    <= '0;
      fin_r     <= 1'b0;
      lastblk_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      round_r   <= round_nxt;
      word_r    <= word_nxt;
      fin_r     <= fin_nxt;
      lastblk_r <= lastblk_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sha256_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_dp
// Datapath: 512-bit block shift register that doubles as the rolling
// schedule window, working variables, one round per cycle, hash state.
// ----------------------------------------------------------------------------
module sha256_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          data_byte,
  input  sha256_pkg::dp_cmd_t cmd,
  output sha256_pkg::dp_sts_t sts,
  output logic [31:0]         digest_word
);

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  logic [511:0]    blk_r;
  logic [31:0]     v_r [8];
  logic [31:0]     hash_r [8];
  logic [5:0]      fill_r;
  logic [60:0]     count_r;

  logic [7:0][7:0] len_v;
  logic [7:0]      byte_in;
  logic [31:0]     w;
  logic [31:0]     t1;
  logic [31:0]     t2;

  assign sts.fill    = fill_r;
  assign digest_word = hash_r[cmd.word_idx];
  assign len_v       = {count_r, 3'b000};

  always_comb begin
    case (cmd.byte_src)
      sha256_pkg::SRC_DATA:  byte_in = data_byte;
      sha256_pkg::SRC_PAD80: byte_in = sha256_pkg::PAD_BYTE;
      sha256_pkg::SRC_LEN:   byte_in = len_v[~fill_r[2:0]];
      default:               byte_in = 8'h00;
    endcase
  end

  // window word k sits at blk_r[511-32k -: 32]; word 0 is the oldest
  always_comb begin
    if (cmd.round_idx < 6'd16) begin
      w = blk_r[511:480];
    end else begin
      w = small_sig1(blk_r[63:32]) + blk_r[223:192] + small_sig0(blk_r[479:448])
          + blk_r[511:480];
    end
    t1 = v_r[7] + big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + sha256_pkg::ROUND_K[cmd.round_idx] + w;
    t2 = big_sig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      blk_r <= {blk_r[503:0], byte_in};
    end else if (cmd.round_en) begin
      blk_r <= {blk_r[479:0], w};
    end
    if (cmd.load_vars) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= hash_r[i];
      end
    end else if (cmd.round_en) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.hash_init) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= sha256_pkg::HASH_IV[i];
      end
      fill_r  <= '0;
      count_r <= '0;
    end else begin
      if (cmd.shift_en) begin
        fill_r <= fill_r + 6'd1;
      end
      if (cmd.count_inc) begin
        count_r <= count_r + 61'd1;
      end
      if (cmd.hash_add) begin
        for (int i = 0; i < 8; i++) begin
          hash_r[i] <= hash_r[i] + v_r[i];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sha256_byte_stream_hasher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, one byte per input beat.
//
// Input channel in_ch: op = 0 absorbs data_byte, op = 1 finishes the message.
// Output channel out_ch: eight digest words, word_index 0..7, last_word on 7.
// The beat that completes a 64-byte block is followed by the compression
// rounds and the hash update, during which ready is low; the round unit
// does one round per cycle. A finish beat runs the pad sequencer, one pad
// byte per cycle up to the block end, then the rounds and hash update; when
// 56 or more bytes were buffered a second pad block follows with its own
// rounds and hash update. Then the eight digest beats, one per cycle while
// out_ch.ready is high.
// Input is taken only while no block or digest is in progress. A stalled
// receiver holds the current digest word; the next message starts after the
// last word is taken.
// Reset loads the initial hash values and clears the byte and length counts.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input  logic         clk,
  input  logic         rst_n,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);

  sha256_pkg::dp_cmd_t cmd;
  sha256_pkg::dp_sts_t sts;

  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .data_byte   (in_ch.data_byte),
    .cmd         (cmd),
    .sts         (sts),
    .digest_word (out_ch.digest_word)
  );

  assign out_ch.word_index = cmd.word_idx;
  assign out_ch.last_word  = (cmd.word_idx == sha256_pkg::WORD_LAST);

endmodule
`default_nettype wire
